FILE: rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UTF8D_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8d check failed in the same cycle");
`define UTF8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8d check failed one cycle later");
`else
`define UTF8D_ASSERT_SAME(label, ante, cons)
`define UTF8D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // One queued job: rep_count replacements, then the decoded value if any.
    typedef struct packed {
        logic [2:0]      rep_count;
        logic            has_value;
        logic [CP_W-1:0] value;
        logic            text_last;
    } utf8d_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } utf8d_q_status_t;

endpackage

FILE: rtl/utf8d_byte_if.sv
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

FILE: rtl/utf8d_cp_if.sv
interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_replacement;
    logic        run_last;
    logic        text_end;

    modport source (output valid, output code_point, output is_replacement,
                    output run_last, output text_end, input ready);
    modport sink (input valid, input code_point, input is_replacement,
                  input run_last, input text_end, output ready);
endinterface

FILE: rtl/utf8d_front.sv
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    utf8d_byte_if.sink      byte_stream,
    input  utf8d_q_status_t q_status,
    output logic            push,
    output utf8d_cmd_t      cmd
);

    localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP_2 = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3 = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4 = 21'h010000;

    logic [2:0]      exp_len_reg, exp_len_next;
    logic [2:0]      seen_reg, seen_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic [7:0]      c;
    logic            last;
    logic            accept;
    logic            pending;
    logic            is_cont;

    logic            lead_ascii;
    logic            lead_multi;
    logic            lead_rep;
    logic            lead_start;
    logic [2:0]      lead_len;
    logic [CP_W-1:0] lead_bits;

    logic [CP_W-1:0] acc;
    logic [2:0]      seen_inc;
    logic            complete;
    logic            overlong;
    logic            value_ok;

    assign c       = byte_stream.data_byte;
    assign last    = byte_stream.end_of_input;
    assign accept  = byte_stream.valid && byte_stream.ready;
    assign pending = (exp_len_reg != 3'd0);
    assign is_cont = (c[7:6] == 2'b10);

    assign byte_stream.ready = !q_status.full;

    // Lead byte decode
    always_comb
    begin
        lead_ascii = !c[7];
        lead_len   = 3'd0;
        lead_bits  = '0;
        if (c[7:5] == 3'b110)
        begin
            lead_len  = 3'd2;
            lead_bits = {16'd0, c[4:0]};
        end
        else if (c[7:4] == 4'b1110)
        begin
            lead_len  = 3'd3;
            lead_bits = {17'd0, c[3:0]};
        end
        else if (c[7:3] == 5'b11110)
        begin
            lead_len  = 3'd4;
            lead_bits = {18'd0, c[2:0]};
        end
        lead_multi = (lead_len != 3'd0);
        lead_rep   = (!lead_ascii && !lead_multi) || (lead_multi && last);
        lead_start = lead_multi && !last;
    end

    // Continuation accumulate and range check
    assign acc      = {partial_reg[CP_W-7:0], c[5:0]};
    assign seen_inc = seen_reg + 3'd1;
    assign complete = (seen_inc >= exp_len_reg);

    always_comb
    begin
        case (exp_len_reg)
            3'd2:    overlong = (acc < MIN_CP_2);
            3'd3:    overlong = (acc < MIN_CP_3);
            3'd4:    overlong = (acc < MIN_CP_4);
            default: overlong = 1'b0;
        endcase
        value_ok = !overlong && (acc <= MAX_CP) && !(acc inside {[SURR_LO:SURR_HI]});
    end

    always_comb
    begin
        exp_len_next  = exp_len_reg;
        seen_next     = seen_reg;
        partial_next  = partial_reg;
        cmd.rep_count = 3'd0;
        cmd.has_value = 1'b0;
        cmd.value     = {13'd0, c};
        cmd.text_last = last;

        if (!pending || !is_cont)
        begin
            // Flush an interrupted sequence, then treat the byte as a lead
            cmd.rep_count = (pending ? seen_reg : 3'd0) + {2'd0, lead_rep};
            cmd.has_value = lead_ascii;
            exp_len_next  = lead_start ? lead_len : 3'd0;
            seen_next     = lead_start ? 3'd1 : 3'd0;
            partial_next  = lead_start ? lead_bits : '0;
        end
        else if (complete)
        begin
            cmd.value     = acc;
            cmd.has_value = value_ok;
            cmd.rep_count = value_ok ? 3'd0 : exp_len_reg;
            exp_len_next  = 3'd0;
            seen_next     = 3'd0;
            partial_next  = '0;
        end
        else if (last)
        begin
            cmd.rep_count = 3'd1;
        end
        else
        begin
            seen_next    = seen_inc;
            partial_next = acc;
        end

        if (last)
        begin
            exp_len_next = 3'd0;
            seen_next    = 3'd0;
            partial_next = '0;
        end
    end

    assign push = accept && ((cmd.rep_count != 3'd0) || cmd.has_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= 3'd0;
            seen_reg    <= 3'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
        end
    end

endmodule

FILE: rtl/utf8d_queue.sv
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utf8d_cmd_t      push_cmd,
    input  logic            pop,
    output utf8d_cmd_t      head_cmd,
    output utf8d_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf8d_cmd_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/utf8d_back.sv
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  utf8d_cmd_t      head_cmd,
    input  utf8d_q_status_t q_status,
    output logic            pop,
    utf8d_cp_if.source      char_stream
);

    logic [1:0]      idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [CP_W-1:0] cp_reg;
    logic            rep_reg;
    logic            run_last_reg;
    logic            text_end_reg;

    logic            load;
    logic            fire;
    logic [2:0]      total;
    logic            is_final;
    logic            is_rep;

    assign load     = !out_valid_reg || char_stream.ready;
    assign fire     = load && !q_status.empty;
    assign total    = head_cmd.rep_count + {2'd0, head_cmd.has_value};
    assign is_final = ({1'b0, idx_reg} == (total - 3'd1));
    assign is_rep   = ({1'b0, idx_reg} < head_cmd.rep_count);
    assign pop      = fire && is_final;

    // Step through the head job one result per beat
    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = is_final ? 2'd0 : idx_reg + 2'd1;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (char_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cp_reg       <= is_rep ? REPLACEMENT_CP : head_cmd.value;
            rep_reg      <= is_rep;
            run_last_reg <= is_final;
            text_end_reg <= is_final && head_cmd.text_last;
        end
    end

    assign char_stream.valid          = out_valid_reg;
    assign char_stream.code_point     = cp_reg;
    assign char_stream.is_replacement = rep_reg;
    assign char_stream.run_last       = run_last_reg;
    assign char_stream.text_end       = text_end_reg;

endmodule

FILE: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: takes one byte per beat on byte_stream and sends Unicode
// scalar values on char_stream, with U+FFFD and is_replacement set for malformed
// input (bad lead, interrupted sequence, overlong/surrogate/out-of-range value, or
// a text that ends mid-sequence). run_last marks the last result caused by a byte
// and text_end the last result of a text. A byte is taken every cycle while the
// command queue (QUEUE_DEPTH entries) has room; the front stage decodes it in that
// same cycle. While the queue holds a job and char_stream is not stalled, the back
// stage emits one result per cycle from the queue head into a registered output;
// a byte yielding k results holds the back stage until all k are out; unstalled,
// well-formed text runs at one byte per cycle; pending continuations bypass it.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    utf8d_byte_if.sink byte_stream,
    utf8d_cp_if.source char_stream
);

    utf8d_cmd_t      push_cmd;
    utf8d_cmd_t      head_cmd;
    utf8d_q_status_t q_status;
    logic            push;
    logic            pop;

    // Front: classify the byte, track the open sequence, queue its results
    utf8d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .q_status    (q_status),
        .push        (push),
        .cmd         (push_cmd)
    );

    // Queue: decouple decode from the output handshake
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back: expand each job into result beats
    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .char_stream (char_stream)
    );

    // A job never leaves an empty queue
    `UTF8D_ASSERT_SAME(a_pop_nonempty, pop, !q_status.empty)
    // A job's beats are back to back: more follow until run_last
    `UTF8D_ASSERT_NEXT(a_run_continues, char_stream.valid && !char_stream.run_last, char_stream.valid)
    // Text end only on the final beat of a byte
    `UTF8D_ASSERT_SAME(a_end_is_last, char_stream.valid && char_stream.text_end, char_stream.run_last)
    // Replacement beats carry U+FFFD
    `UTF8D_ASSERT_SAME(a_rep_value, char_stream.valid && char_stream.is_replacement, char_stream.code_point == REPLACEMENT_CP)

endmodule
